FILE: rtl/block_average_mosaic_macros.svh
`ifndef BLOCK_AVERAGE_MOSAIC_MACROS_SVH
`define BLOCK_AVERAGE_MOSAIC_MACROS_SVH

// same-cycle implication, checked outside reset
`define BAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bam assertion failed");

// next-cycle implication, checked outside reset
`define BAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bam assertion failed");

`endif

FILE: rtl/bam_pkg.sv
package bam_pkg;

  localparam int MAX_WIDTH_DFLT = 4096;
  localparam int MAX_CELL_DFLT  = 64;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_CELL       = 2;
  localparam int NCH            = 3;

  localparam int POS_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int CS_W    = 7;
  localparam int PIX_W   = 8;
  localparam int AVG_W   = 8;
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  localparam int REG_NUM = 5;
  localparam int PA_W    = $clog2(4 * REG_NUM);
  localparam int IDX_W   = PA_W - 2;
  localparam int DATA_W  = 32;

  localparam logic [POS_W-1:0]  AREA_LEFT_RST   = '0;
  localparam logic [POS_W-1:0]  AREA_TOP_RST    = '0;
  localparam logic [SIZE_W-1:0] AREA_WIDTH_RST  = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] AREA_HEIGHT_RST = SIZE_W'(1);
  localparam logic [CS_W-1:0]   CELL_SIZE_RST   = CS_W'(12);

  typedef enum logic [IDX_W-1:0] {
    REG_AREA_LEFT,
    REG_AREA_TOP,
    REG_AREA_WIDTH,
    REG_AREA_HEIGHT,
    REG_CELL_SIZE
  } bam_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]  area_left;
    logic [POS_W-1:0]  area_top;
    logic [SIZE_W-1:0] area_width;
    logic [SIZE_W-1:0] area_height;
    logic [CS_W-1:0]   cell_size;
  } bam_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } bam_in_t;

  typedef struct packed {
    logic [POS_W-1:0] cell_x;
    logic [POS_W-1:0] cell_y;
    logic [CS_W-1:0]  cell_w;
    logic [CS_W-1:0]  cell_h;
    logic [AVG_W-1:0] avg_red;
    logic [AVG_W-1:0] avg_green;
    logic [AVG_W-1:0] avg_blue;
    logic             last_cell;
  } bam_out_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_step;
    logic out_load;
  } bam_cmd_t;

  typedef struct packed {
    logic cell_done;
    logic div_last;
    logic out_free;
  } bam_sts_t;

endpackage

FILE: rtl/bam_regs.sv
module bam_regs import bam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PA_W-1:0]   paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output bam_cfg_t          cfg,
  output logic              pos_clear
);

  bam_cfg_t cfg_r;
  bam_reg_t reg_idx;
  logic     wr_en;
  logic     idx_ok;

  assign reg_idx = bam_reg_t'(paddr[PA_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    unique case (reg_idx)
      REG_AREA_LEFT, REG_AREA_TOP, REG_AREA_WIDTH,
      REG_AREA_HEIGHT, REG_CELL_SIZE: idx_ok = 1'b1;
      default: idx_ok = 1'b0;
    endcase
  end

  assign pos_clear = wr_en & idx_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_left   <= AREA_LEFT_RST;
      cfg_r.area_top    <= AREA_TOP_RST;
      cfg_r.area_width  <= AREA_WIDTH_RST;
      cfg_r.area_height <= AREA_HEIGHT_RST;
      cfg_r.cell_size   <= CELL_SIZE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_AREA_LEFT:   cfg_r.area_left   <= pwdata[POS_W-1:0];
        REG_AREA_TOP:    cfg_r.area_top    <= pwdata[POS_W-1:0];
        REG_AREA_WIDTH:  cfg_r.area_width  <= pwdata[SIZE_W-1:0];
        REG_AREA_HEIGHT: cfg_r.area_height <= pwdata[SIZE_W-1:0];
        REG_CELL_SIZE:   cfg_r.cell_size   <= pwdata[CS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AREA_LEFT:   prdata = DATA_W'(cfg_r.area_left);
      REG_AREA_TOP:    prdata = DATA_W'(cfg_r.area_top);
      REG_AREA_WIDTH:  prdata = DATA_W'(cfg_r.area_width);
      REG_AREA_HEIGHT: prdata = DATA_W'(cfg_r.area_height);
      REG_CELL_SIZE:   prdata = DATA_W'(cfg_r.cell_size);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bam_ctrl.sv
`include "block_average_mosaic_macros.svh"

module bam_ctrl import bam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output bam_cmd_t cmd,
  input  bam_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_DIV,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ADD;
        end
      end
      S_ADD: begin
        cmd.update = 1'b1;
        state_nxt  = sts.cell_done ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  `BAM_ASSERT_IMP(a_stall_matches_state, clk, rst_n, 1'b1, in_stall == (state_r != S_IDLE))
  `BAM_ASSERT_IMP(a_cmd_onehot, clk, rst_n, 1'b1,
                  $onehot0({cmd.capture, cmd.update, cmd.div_step, cmd.out_load}))
  `BAM_ASSERT_NEXT(a_word_blocks_next, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

FILE: rtl/bam_dp.sv
`include "block_average_mosaic_macros.svh"

module bam_dp import bam_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DFLT,
  parameter int MAX_CELL  = MAX_CELL_DFLT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bam_cfg_t cfg,
  input  logic     pos_clear,
  input  bam_cmd_t cmd,
  output bam_sts_t sts,
  input  bam_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output bam_out_t out_word
);

  localparam int CS_CAP = (1 << CS_W) - 1;
  localparam int CS_MAX = (MAX_CELL < CS_CAP) ? MAX_CELL : CS_CAP;
  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int AW     = $clog2(DEPTH);
  localparam int WW     = $clog2(MAX_WIDTH);
  localparam int CIW    = $clog2(CS_MAX);
  localparam int SW     = $clog2(CS_MAX * CS_MAX * 255 + 1);
  localparam int CNW    = $clog2(CS_MAX * CS_MAX + 1);
  localparam int DW     = CNW + AVG_W - 1;
  localparam int XW     = (SW > DW) ? SW + 1 : DW + 1;
  localparam int STEP_W = $clog2(AVG_W);

  // effective configuration
  logic [WW:0]      w_eff;
  logic [ROW_W:0]   h_eff;
  logic [CS_W-1:0]  cs;

  // position
  logic [WW-1:0]    col_pos_r, col_pos_nxt;
  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [CIW-1:0]   col_in_cell_r, col_in_cell_nxt;
  logic [CIW-1:0]   row_in_band_r, row_in_band_nxt;
  logic [AW-1:0]    cell_idx_r, cell_idx_nxt;

  logic [WW-1:0]    cell_left;
  logic [ROW_W-1:0] band_top;
  logic [WW:0]      cw_full;
  logic [ROW_W:0]   ch_full;
  logic [CS_W-1:0]  cw, ch;
  logic [WW:0]      col_pos_inc;
  logic [ROW_W:0]   row_pos_inc;
  logic [CIW:0]     cic_inc, rib_inc;
  logic             row_end, last_row, cell_wrap, band_wrap, fresh, cell_done;
  logic [2*CS_W-1:0] prod;
  logic [CNW-1:0]   cnt;

  // sums and divider
  logic [NCH-1:0][SW-1:0]    mem [DEPTH];
  logic [NCH-1:0][SW-1:0]    rdata_r;
  logic [NCH-1:0][PIX_W-1:0] pix_r;
  logic [NCH-1:0][SW-1:0]    sum_new;
  logic [NCH-1:0][SW-1:0]    rem_r;
  logic [NCH-1:0][AVG_W-1:0] q_r;
  logic [NCH-1:0]            ge;
  logic [DW-1:0]             dv_r;
  logic [STEP_W-1:0]         step_r;
  bam_out_t                  meta_r, meta_nxt, out_nxt, out_word_r;
  logic                      out_valid_r;

  always_comb begin
    if (cfg.area_width == '0) w_eff = (WW+1)'(1);
    else if (32'(cfg.area_width) > 32'(MAX_WIDTH)) w_eff = (WW+1)'(MAX_WIDTH);
    else w_eff = (WW+1)'(cfg.area_width);
    if (cfg.area_height == '0) h_eff = (ROW_W+1)'(1);
    else if (32'(cfg.area_height) > 32'(MAX_HEIGHT)) h_eff = (ROW_W+1)'(MAX_HEIGHT);
    else h_eff = (ROW_W+1)'(cfg.area_height);
    if (32'(cfg.cell_size) < 32'(MIN_CELL)) cs = CS_W'(MIN_CELL);
    else if (32'(cfg.cell_size) > 32'(CS_MAX)) cs = CS_W'(CS_MAX);
    else cs = cfg.cell_size;
  end

  assign cell_left   = col_pos_r - WW'(col_in_cell_r);
  assign band_top    = row_pos_r - ROW_W'(row_in_band_r);
  assign cw_full     = w_eff - {1'b0, cell_left};
  assign ch_full     = h_eff - {1'b0, band_top};
  assign cw          = (32'(cw_full) > 32'(cs)) ? cs : CS_W'(cw_full);
  assign ch          = (32'(ch_full) > 32'(cs)) ? cs : CS_W'(ch_full);
  assign col_pos_inc = {1'b0, col_pos_r} + (WW+1)'(1);
  assign row_pos_inc = {1'b0, row_pos_r} + (ROW_W+1)'(1);
  assign cic_inc     = {1'b0, col_in_cell_r} + (CIW+1)'(1);
  assign rib_inc     = {1'b0, row_in_band_r} + (CIW+1)'(1);
  assign row_end     = col_pos_inc >= w_eff;
  assign last_row    = row_pos_inc >= h_eff;
  assign cell_wrap   = 32'(cic_inc) >= 32'(cs);
  assign band_wrap   = 32'(rib_inc) >= 32'(cs);
  assign fresh       = (row_in_band_r == '0) && (col_in_cell_r == '0);
  assign cell_done   = (32'(cic_inc) == 32'(cw)) && (32'(rib_inc) == 32'(ch));
  assign prod        = (2*CS_W)'(cw) * (2*CS_W)'(ch);
  assign cnt         = CNW'(prod);

  always_comb begin
    col_pos_nxt     = col_pos_r;
    row_pos_nxt     = row_pos_r;
    col_in_cell_nxt = col_in_cell_r;
    row_in_band_nxt = row_in_band_r;
    cell_idx_nxt    = cell_idx_r;
    if (pos_clear) begin
      col_pos_nxt     = '0;
      row_pos_nxt     = '0;
      col_in_cell_nxt = '0;
      row_in_band_nxt = '0;
      cell_idx_nxt    = '0;
    end else if (cmd.update) begin
      col_pos_nxt     = WW'(col_pos_inc);
      col_in_cell_nxt = cell_wrap ? '0 : CIW'(cic_inc);
      cell_idx_nxt    = cell_wrap ? cell_idx_r + AW'(1) : cell_idx_r;
      if (row_end) begin
        col_pos_nxt     = '0;
        col_in_cell_nxt = '0;
        cell_idx_nxt    = '0;
        row_pos_nxt     = ROW_W'(row_pos_inc);
        row_in_band_nxt = band_wrap ? '0 : CIW'(rib_inc);
        if (last_row) begin
          row_pos_nxt     = '0;
          row_in_band_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r     <= '0;
      row_pos_r     <= '0;
      col_in_cell_r <= '0;
      row_in_band_r <= '0;
      cell_idx_r    <= '0;
    end else begin
      col_pos_r     <= col_pos_nxt;
      row_pos_r     <= row_pos_nxt;
      col_in_cell_r <= col_in_cell_nxt;
      row_in_band_r <= row_in_band_nxt;
      cell_idx_r    <= cell_idx_nxt;
    end
  end

  // band sums: read on capture, write back on update
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_new[c] = (fresh ? '0 : rdata_r[c]) + SW'(pix_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) mem[cell_idx_r] <= sum_new;
    if (cmd.capture) begin
      rdata_r  <= mem[cell_idx_r];
      pix_r[0] <= in_word.red_in;
      pix_r[1] <= in_word.green_in;
      pix_r[2] <= in_word.blue_in;
    end
  end

  // restoring divider, one quotient bit per step for all channels
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ge[c] = XW'(rem_r[c]) >= XW'(dv_r);
    end
  end

  always_comb begin
    meta_nxt           = '0;
    meta_nxt.cell_x    = cfg.area_left + POS_W'(cell_left);
    meta_nxt.cell_y    = cfg.area_top + POS_W'(band_top);
    meta_nxt.cell_w    = cw;
    meta_nxt.cell_h    = ch;
    meta_nxt.last_cell = row_end && last_row;
  end

  always_ff @(posedge clk) begin
    if (cmd.update && cell_done) begin
      rem_r  <= sum_new;
      dv_r   <= {cnt, {(AVG_W-1){1'b0}}};
      step_r <= STEP_W'(AVG_W - 1);
      meta_r <= meta_nxt;
    end else if (cmd.div_step) begin
      for (int c = 0; c < NCH; c++) begin
        if (ge[c]) rem_r[c] <= SW'(XW'(rem_r[c]) - XW'(dv_r));
        q_r[c] <= {q_r[c][AVG_W-2:0], ge[c]};
      end
      dv_r   <= dv_r >> 1;
      step_r <= step_r - STEP_W'(1);
    end
  end

  // output register
  always_comb begin
    out_nxt           = meta_r;
    out_nxt.avg_red   = q_r[0];
    out_nxt.avg_green = q_r[1];
    out_nxt.avg_blue  = q_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_word_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign sts.cell_done = cell_done;
  assign sts.div_last  = (step_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  `BAM_ASSERT_IMP(a_cell_counters, clk, rst_n, 1'b1,
                  (32'(col_in_cell_r) < 32'(cs)) && (32'(row_in_band_r) < 32'(cs)))
  `BAM_ASSERT_IMP(a_pos_in_area, clk, rst_n, 1'b1,
                  ({1'b0, col_pos_r} < w_eff) && ({1'b0, row_pos_r} < h_eff))
  `BAM_ASSERT_IMP(a_quotient_fits, clk, rst_n, cmd.div_step,
                  (XW'(rem_r[0]) < (XW'(dv_r) << 1)) && (XW'(rem_r[1]) < (XW'(dv_r) << 1)) &&
                  (XW'(rem_r[2]) < (XW'(dv_r) << 1)))

endmodule

FILE: rtl/block_average_mosaic.sv
// Block-average mosaic over a clipped image area. Pixels arrive in raster order;
// the area is cut into square cells anchored at its top-left corner, and on the
// last pixel of each cell one word carries the cell's image position, its
// clipped size and its truncated mean color. A pixel that does not close a cell
// is captured with a registered read of the per-cell band sum, then added and
// written back into the sum memory (MAX_WIDTH/2 entries, one port). A pixel that
// closes a cell also runs the restoring divider shared by the three channels and
// waits, if needed, for the output register to empty. The output register lets
// the next pixel enter while a result is still held. Sum entries are overwritten
// at the first pixel of each cell band, so the memory needs no clearing pass
// after reset. A write to any of the five registers restarts the area.
module block_average_mosaic import bam_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DFLT,
  parameter int MAX_CELL  = MAX_CELL_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PA_W-1:0]   paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  bam_in_t           in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output bam_out_t          out_word
);

  bam_cfg_t cfg;
  logic     pos_clear;
  bam_cmd_t cmd;
  bam_sts_t sts;

  bam_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .pos_clear (pos_clear)
  );

  bam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bam_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_CELL  (MAX_CELL)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pos_clear (pos_clear),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: bench/block_average_mosaic_test.sv
`default_nettype none

module block_average_mosaic_test;
  import bam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_DEPTH     = MAX_WIDTH_DFLT / 2;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_TAIL    = 40;
  localparam int QUIET_LIMIT   = 5000;
  localparam int RANDOM_PIXELS = 560;
  localparam int IDLE_PCT      = 19;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PA_W-1:0]   paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  bam_in_t           in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bam_out_t          out_word;

  block_average_mosaic uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block: registers, band sums and raster position
  bam_cfg_t    regs;
  logic [19:0] band_red   [SUM_DEPTH];
  logic [19:0] band_green [SUM_DEPTH];
  logic [19:0] band_blue  [SUM_DEPTH];
  int unsigned col_pos, row_pos, col_in_cell, row_in_band;

  bam_out_t    cells_due[$];
  bam_out_t    cell_want;
  int          mismatches = 0;
  int          cells_checked = 0;
  int          pixels_sent = 0;
  int          settings_used = 0;
  int          idle_pct = IDLE_PCT;
  int          stall_pct = IDLE_PCT;
  int          quiet_cycles = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clamp_to(32'(regs.area_width), 1, MAX_WIDTH_DFLT);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_to(32'(regs.area_height), 1, MAX_HEIGHT);
  endfunction

  function automatic int unsigned eff_side();
    return clamp_to(32'(regs.cell_size), MIN_CELL, MAX_CELL_DFLT);
  endfunction

  function automatic void restart_raster();
    col_pos = 0;
    row_pos = 0;
    col_in_cell = 0;
    row_in_band = 0;
  endfunction

  function automatic void mirror_reset();
    regs.area_left   = AREA_LEFT_RST;
    regs.area_top    = AREA_TOP_RST;
    regs.area_width  = AREA_WIDTH_RST;
    regs.area_height = AREA_HEIGHT_RST;
    regs.cell_size   = CELL_SIZE_RST;
    for (int i = 0; i < SUM_DEPTH; i++) begin
      band_red[i] = '0;
      band_green[i] = '0;
      band_blue[i] = '0;
    end
    restart_raster();
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_AREA_LEFT:   regs.area_left   = value[POS_W-1:0];
      REG_AREA_TOP:    regs.area_top    = value[POS_W-1:0];
      REG_AREA_WIDTH:  regs.area_width  = value[SIZE_W-1:0];
      REG_AREA_HEIGHT: regs.area_height = value[SIZE_W-1:0];
      REG_CELL_SIZE:   regs.cell_size   = value[CS_W-1:0];
      default:         return;
    endcase
    restart_raster();
  endfunction

  function automatic void accumulate_pixel(bam_in_t px);
    int unsigned w_eff, h_eff, side, k, left, top, cw, ch, cnt;
    bam_out_t    want_word;
    w_eff = eff_width();
    h_eff = eff_height();
    side  = eff_side();
    k     = col_pos / side;
    left  = col_pos - col_in_cell;
    top   = row_pos - row_in_band;
    cw    = w_eff - left;
    ch    = h_eff - top;
    if (cw > side) cw = side;
    if (ch > side) ch = side;
    if (k >= SUM_DEPTH) k = SUM_DEPTH - 1;

    if (row_in_band == 0 && col_in_cell == 0) begin
      band_red[k]   = 20'(px.red_in);
      band_green[k] = 20'(px.green_in);
      band_blue[k]  = 20'(px.blue_in);
    end else begin
      band_red[k]   = band_red[k] + px.red_in;
      band_green[k] = band_green[k] + px.green_in;
      band_blue[k]  = band_blue[k] + px.blue_in;
    end

    if (col_in_cell + 1 == cw && row_in_band + 1 == ch) begin
      cnt = cw * ch;
      want_word.cell_x    = POS_W'(regs.area_left + left);
      want_word.cell_y    = POS_W'(regs.area_top + top);
      want_word.cell_w    = CS_W'(cw);
      want_word.cell_h    = CS_W'(ch);
      want_word.avg_red   = AVG_W'(band_red[k] / cnt);
      want_word.avg_green = AVG_W'(band_green[k] / cnt);
      want_word.avg_blue  = AVG_W'(band_blue[k] / cnt);
      want_word.last_cell = (col_pos + 1 == w_eff && row_pos + 1 == h_eff);
      cells_due.push_back(want_word);
    end

    col_in_cell++;
    col_pos++;
    if (col_in_cell >= side) col_in_cell = 0;
    if (col_pos >= w_eff) begin
      col_pos = 0;
      col_in_cell = 0;
      row_in_band++;
      row_pos++;
      if (row_in_band >= side) row_in_band = 0;
      if (row_pos >= h_eff) begin
        row_pos = 0;
        row_in_band = 0;
      end
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cells_due.size() == 0) begin
        $error("cell word with nothing expected: x=%0d y=%0d", out_word.cell_x,
               out_word.cell_y);
        mismatches++;
      end else begin
        cell_want = cells_due.pop_front();
        check_field("cell_x", 32'(cell_want.cell_x), 32'(out_word.cell_x));
        check_field("cell_y", 32'(cell_want.cell_y), 32'(out_word.cell_y));
        check_field("cell_w", 32'(cell_want.cell_w), 32'(out_word.cell_w));
        check_field("cell_h", 32'(cell_want.cell_h), 32'(out_word.cell_h));
        check_field("avg_red", 32'(cell_want.avg_red), 32'(out_word.avg_red));
        check_field("avg_green", 32'(cell_want.avg_green), 32'(out_word.avg_green));
        check_field("avg_blue", 32'(cell_want.avg_blue), 32'(out_word.avg_blue));
        check_field("last_cell", 32'(cell_want.last_cell), 32'(out_word.last_cell));
        cells_checked++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d cells outstanding",
               quiet_cycles, cells_due.size());
      $display("** block_average_mosaic: FAILED **");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] random_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  function automatic bam_in_t random_pixel();
    bam_in_t px;
    px.red_in   = random_level();
    px.green_in = random_level();
    px.blue_in  = random_level();
    return px;
  endfunction

  function automatic logic [DATA_W-1:0] with_noise(int unsigned field, int bits);
    return ($urandom() << bits) | field;
  endfunction

  task automatic send_pixel(input bam_in_t px);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_pixel(px);
    pixels_sent++;
  endtask

  // input parked, all cells out, then time for a pixel still in flight
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic setup_area(input int unsigned left, input int unsigned top,
                            input int unsigned width, input int unsigned height,
                            input int unsigned side);
    settle_block();
    write_reg(REG_AREA_LEFT, with_noise(left, POS_W));
    write_reg(REG_AREA_TOP, with_noise(top, POS_W));
    write_reg(REG_AREA_WIDTH, with_noise(width, SIZE_W));
    write_reg(REG_AREA_HEIGHT, with_noise(height, SIZE_W));
    write_reg(REG_CELL_SIZE, with_noise(side, CS_W));
    settings_used++;
  endtask

  // registers at reset: 1x1 area, so every pixel is its own last cell
  task automatic test_reset_defaults();
    send_pixel({8'hFF, 8'h00, 8'hFF});
    send_pixel({8'h00, 8'hFF, 8'h00});
  endtask

  // clipped right/bottom cells, positions wrapping, then a second area back to back
  task automatic test_clip_and_wrap();
    bam_in_t px;
    setup_area(4094, 4095, 3, 3, 2);
    for (int i = 0; i < 9; i++) begin
      px.red_in   = (i % 2) ? '1 : '0;
      px.green_in = (i % 3 == 0) ? '1 : '0;
      px.blue_in  = PIX_W'(i * 37);
      send_pixel(px);
    end
    repeat (4) send_pixel(random_pixel());
  endtask

  // a write mid-area restarts the raster; cell size 1 acts as 2
  task automatic test_restart_on_write();
    settle_block();
    write_reg(REG_CELL_SIZE, with_noise(1, CS_W));
    repeat (4) send_pixel(random_pixel());
  endtask

  // writes beyond the register file leave the raster where it was
  task automatic test_ignored_index();
    setup_area(100, 200, 2, 2, 0);
    repeat (2) send_pixel(random_pixel());
    settle_block();
    for (int idx = REG_NUM; idx < 2 ** IDX_W; idx++) write_reg(IDX_W'(idx), $urandom());
    repeat (2) send_pixel(random_pixel());
  endtask

  task automatic test_zero_size();
    setup_area(4095, 4095, 0, 0, 64);
    repeat (2) send_pixel(random_pixel());
  endtask

  // oversize width, narrowest cells; the row is cut short by the next write
  task automatic test_wide_row();
    setup_area(0, 7, 8191, 0, 0);
    repeat (96) send_pixel(random_pixel());
  endtask

  // oversize height, oversize cell clamps to the largest cell size
  task automatic test_tall_column();
    setup_area(4095, 1, 1, 8191, 127);
    repeat (160) send_pixel(random_pixel());
  endtask

  // one large clipped cell, all white
  task automatic test_full_cell();
    setup_area(4088, 4088, 16, 16, 64);
    repeat (16 * 16) send_pixel('1);
  endtask

  task automatic test_random_areas();
    int unsigned start, width, height, side, left, top, areas, total, cut, room;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (pixels_sent - start >= 150 && pixels_sent - start < 400) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
      end
      case ($urandom_range(9))
        0:       width = 0;
        1:       width = $urandom_range(25, 48);
        default: width = $urandom_range(1, 16);
      endcase
      case ($urandom_range(9))
        0:       height = 0;
        1:       height = $urandom_range(13, 24);
        default: height = $urandom_range(1, 8);
      endcase
      case ($urandom_range(9))
        0:       side = $urandom_range(0, 1);
        1:       side = $urandom_range(65, 127);
        2:       side = $urandom_range(10, 64);
        default: side = $urandom_range(2, 6);
      endcase
      left = ($urandom_range(3) == 0) ? 4095 - $urandom_range(0, 30) : $urandom_range(0, 4095);
      top  = ($urandom_range(3) == 0) ? 4095 - $urandom_range(0, 30) : $urandom_range(0, 4095);
      setup_area(left, top, width, height, side);
      areas = $urandom_range(1, 3);
      total = eff_width() * eff_height();
      for (int a = 0; a < areas; a++) begin
        cut = ($urandom_range(99) < 12) ? $urandom_range(0, total - 1) : total;
        room = RANDOM_PIXELS - (pixels_sent - start);
        if (cut > room) cut = room;
        repeat (cut) send_pixel(random_pixel());
        if (cut < total) break;
        if ($urandom_range(9) == 0) settle_block();
      end
    end
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("%0d pixels over %0d register settings, %0d cell words checked", pixels_sent,
             settings_used, cells_checked);
    $display("covered clipping, position wrap, size saturation and raster restarts");
    if (mismatches == 0) begin
      $display("** block_average_mosaic: PASSED **");
    end else begin
      $display("** block_average_mosaic: FAILED **");
    end
    $finish;
  endtask

  initial begin
    mirror_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_clip_and_wrap();
    test_restart_on_write();
    test_ignored_index();
    test_zero_size();
    test_wide_row();
    test_tall_column();
    test_full_cell();
    test_random_areas();
    finish_run();
  end

endmodule

`default_nettype wire
